// ===== hdl/ps2s1_pkg.sv =====
package ps2s1_pkg;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic prefix;
    } t_flags;

    localparam logic [7:0] SC_PREFIX   = 8'hE0;
    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [6:0] SC_CTRL     = 7'h1D;
    localparam logic [6:0] SC_LSHIFT   = 7'h2A;
    localparam logic [6:0] SC_RSHIFT   = 7'h36;
    localparam logic [6:0] SC_UP       = 7'h48;
    localparam logic [6:0] SC_DOWN     = 7'h50;
    localparam logic [6:0] SC_LEFT     = 7'h4B;
    localparam logic [6:0] SC_RIGHT    = 7'h4D;
    localparam logic [6:0] SC_DELETE   = 7'h53;

    localparam logic [7:0] CH_UP       = 8'h80;
    localparam logic [7:0] CH_DOWN     = 8'h81;
    localparam logic [7:0] CH_LEFT     = 8'h82;
    localparam logic [7:0] CH_RIGHT    = 8'h83;
    localparam logic [7:0] CH_DELETE   = 8'h7F;
    localparam logic [7:0] CTRL_MASK   = 8'h1F;

    localparam int         KEYMAP_LEN  = 58;

    localparam logic [7:0] PLAIN_MAP [0:KEYMAP_LEN-1] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
        8'h00, 8'h20
    };

    localparam logic [7:0] SHIFTED_MAP [0:KEYMAP_LEN-1] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
        8'h00, 8'h20
    };

endpackage

// ===== hdl/ps2s1_xlate.sv =====
module ps2s1_xlate (
    input  logic [7:0]            i_scan_byte,
    input  ps2s1_pkg::t_flags     i_flags,
    output ps2s1_pkg::t_flags     o_flags,
    output logic                  o_res_valid,
    output logic [7:0]            o_character
);

    logic [6:0] code;
    logic       make;
    logic [7:0] key_char;
    logic [7:0] ext_char;
    logic [7:0] map_char;

    assign code = i_scan_byte[6:0];
    assign make = (i_scan_byte & ps2s1_pkg::BREAK_BIT) == 8'h00;

    always_comb begin
        case (code)
            ps2s1_pkg::SC_UP:     ext_char = ps2s1_pkg::CH_UP;
            ps2s1_pkg::SC_DOWN:   ext_char = ps2s1_pkg::CH_DOWN;
            ps2s1_pkg::SC_LEFT:   ext_char = ps2s1_pkg::CH_LEFT;
            ps2s1_pkg::SC_RIGHT:  ext_char = ps2s1_pkg::CH_RIGHT;
            ps2s1_pkg::SC_DELETE: ext_char = ps2s1_pkg::CH_DELETE;
            default:              ext_char = 8'h00;
        endcase
    end

    always_comb begin
        map_char = 8'h00;
        if (32'(code) < ps2s1_pkg::KEYMAP_LEN) begin
            map_char = i_flags.shift ? ps2s1_pkg::SHIFTED_MAP[code[5:0]]
                                     : ps2s1_pkg::PLAIN_MAP[code[5:0]];
        end
    end

    assign key_char = i_flags.prefix ? ext_char : map_char;

    always_comb begin
        o_flags     = i_flags;
        o_res_valid = 1'b0;
        o_character = key_char;
        if (i_scan_byte == ps2s1_pkg::SC_PREFIX) begin
            o_flags.prefix = 1'b1;
        end else if (code == ps2s1_pkg::SC_CTRL) begin
            o_flags.ctrl   = make;
            o_flags.prefix = 1'b0;
        end else if (code inside {ps2s1_pkg::SC_LSHIFT, ps2s1_pkg::SC_RSHIFT}) begin
            o_flags.shift  = make;
            o_flags.prefix = 1'b0;
        end else begin
            o_flags.prefix = 1'b0;
            o_res_valid    = make && (key_char != 8'h00);
            if (i_flags.ctrl) begin
                o_character = key_char & ps2s1_pkg::CTRL_MASK;
            end
        end
    end

endmodule

// ===== hdl/ps2_set1_scancode_to_ascii_unit.sv =====
// each scancode passes through the input register and then the result register
// throughput: one scancode per cycle, limited only by output stall
// the keymap lookup and flag update run in one pass between the input and result registers
// reset (synchronous, active low) clears shift, ctrl, prefix and both valid bits
module ps2_set1_scancode_to_ascii_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_scan_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_character
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    logic [7:0]        r_out_char;
    ps2s1_pkg::t_flags r_flags;
    ps2s1_pkg::t_flags n_flags;
    logic              res_valid;
    logic [7:0]        res_char;
    logic              out_free;
    logic              fire;

    ps2s1_xlate u_xlate (
        .i_scan_byte (r_in_byte),
        .i_flags     (r_flags),
        .o_flags     (n_flags),
        .o_res_valid (res_valid),
        .o_character (res_char)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_character = r_out_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= fire && res_valid;
            end
            if (fire) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_scan_byte;
        end
        if (out_free) begin
            r_out_char <= res_char;
        end
    end

    a_reset_flags: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_flags == '0 && !r_in_valid && !r_out_valid))
        else $error("flags or valids not cleared by reset");

    a_prefix_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_byte == ps2s1_pkg::SC_PREFIX) |=> r_flags.prefix)
        else $error("prefix byte did not set prefix flag");

    a_break_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_byte[7]) |=> !r_out_valid)
        else $error("break code produced a character");

    a_ctrl_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res_valid && r_flags.ctrl) |=> (r_out_valid && o_character[7:5] == 3'b000))
        else $error("character not masked while ctrl held");

endmodule
